// ===== rtl/core/lts_pkg.sv =====
// Lottery ticket scheduler shared package: sizes, status and request codes,
// cell command and result types. No dependencies.
package lts_pkg;
    localparam int TableDepth  = 16;
    localparam int WeightBits  = 8;
    localparam int IdBits      = 8;
    localparam int CountBits   = $clog2(TableDepth + 1);
    localparam int IdxBits     = $clog2(TableDepth);
    localparam int TotalBits   = WeightBits + IdxBits;
    localparam int RandBits    = 32;
    localparam int QuantBits   = 16;

    localparam logic [1:0] KindAdd    = 2'd0;
    localparam logic [1:0] KindRemove = 2'd1;
    localparam logic [1:0] KindTick   = 2'd2;

    localparam logic [2:0] StAdded    = 3'd0;
    localparam logic [2:0] StFull     = 3'd1;
    localparam logic [2:0] StRemoved  = 3'd2;
    localparam logic [2:0] StNotFound = 3'd3;
    localparam logic [2:0] StWait     = 3'd4;
    localparam logic [2:0] StEmpty    = 3'd5;
    localparam logic [2:0] StDrawn    = 3'd6;

    // Shift command to the cell row.
    typedef struct packed {
        logic                 load;     // write new entry at tail position
        logic                 del;      // close the gap at del_idx
        logic [IdxBits-1:0]   wr_idx;
        logic [IdxBits-1:0]   del_idx;
        logic [IdBits-1:0]    id;
        logic [WeightBits-1:0] weight;
    } t_cell_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [IdBits-1:0] winner_id;
        logic              winner_valid;
        logic              running_removed;
    } t_result;
endpackage

// ===== rtl/core/lts_if.sv =====
// Valid/ready channel interfaces for the scheduler requests and results.
// Depends on lts_pkg.
interface lts_req_if import lts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [IdBits-1:0]     entry_id;
    logic [WeightBits-1:0] weight;
    logic [RandBits-1:0]   random_value;
    modport source (output valid, kind, entry_id, weight, random_value, input ready);
    modport sink   (input valid, kind, entry_id, weight, random_value, output ready);
endinterface

interface lts_res_if import lts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [IdBits-1:0] winner_id;
    logic              winner_valid;
    logic              running_removed;
    modport source (output valid, status, winner_id, winner_valid, running_removed,
                    input ready);
    modport sink   (input valid, status, winner_id, winner_valid, running_removed,
                    output ready);
endinterface

// ===== rtl/core/lts_cell.sv =====
// One table cell: holds an id and a weight, takes its right neighbor's entry
// when a gap closes at or below it. Depends on lts_pkg.
module lts_cell import lts_pkg::*; (
    input  logic                  i_clk,
    input  logic [IdxBits-1:0]    i_pos,
    input  t_cell_cmd             i_cmd,
    input  logic [IdBits-1:0]     i_nb_id,
    input  logic [WeightBits-1:0] i_nb_weight,
    output logic [IdBits-1:0]     o_id,
    output logic [WeightBits-1:0] o_weight
);
    logic [IdBits-1:0]     r_id;
    logic [WeightBits-1:0] r_weight;

    // load new entry, or shift from neighbor above the removed slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_cmd.wr_idx == i_pos) begin
            r_id     <= i_cmd.id;
            r_weight <= i_cmd.weight;
        end else if (i_cmd.del && i_pos >= i_cmd.del_idx) begin
            r_id     <= i_nb_id;
            r_weight <= i_nb_weight;
        end
    end

    assign o_id     = r_id;
    assign o_weight = r_weight;
endmodule

// ===== rtl/core/lottery_ticket_scheduler.sv =====
// Lottery ticket scheduler top level: sequencer, modulo unit and cell row.
// Depends on lts_pkg, lts_if, lts_cell.
//
//  channel  | dir | payload
//  i_req    | in  | kind, entry_id, weight, random_value
//  o_res    | out | status, winner_id, winner_valid, running_removed
//  cfg      | in  | i_cfg_we, i_cfg_wdata (quantum_reload)
//
// Add, and a tick that does not draw: accept, then the result stage.
// Remove: accept, a scan of the slots newest first (up to 16, plus a last scan step
// when no id matches), then the result stage.
// Tick with a draw: accept, 32 restoring-division steps (r_bit), a walk over the
// entries oldest first (r_idx, up to 16), then the result stage.
// Reset clears count, total, quantum and running state; table contents stay.
// One request in work at a time; the result stage stalls only while the output
// register still holds a result that has not been taken.
module lottery_ticket_scheduler import lts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [QuantBits-1:0] i_cfg_wdata,
    lts_req_if.sink              i_req,
    lts_res_if.source            o_res
);
    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SScan = 3'd1;
    localparam logic [2:0] SDiv  = 3'd2;
    localparam logic [2:0] SWalk = 3'd3;
    localparam logic [2:0] SOut  = 3'd4;

    logic [2:0]            r_state;
    logic [CountBits-1:0]  r_count;
    logic [TotalBits-1:0]  r_total;
    logic [QuantBits-1:0]  r_quantum, r_reload;
    logic [IdBits-1:0]     r_cur_id, r_key;
    logic                  r_cur_valid;
    logic [CountBits-1:0]  r_idx;
    logic [5:0]            r_bit;
    logic [RandBits-1:0]   r_rand;
    logic [TotalBits:0]    r_rem;
    logic [TotalBits-1:0]  r_acc;
    t_result               r_res;
    t_result               r_out;
    logic                  r_res_valid;

    logic [IdBits-1:0]     cell_id [TableDepth];
    logic [WeightBits-1:0] cell_w  [TableDepth];
    t_cell_cmd             cmd;

    logic [IdxBits-1:0]    idx_lo;
    logic [TotalBits:0]    n_rem;
    logic [TotalBits-1:0]  n_acc;
    logic                  out_free;

    assign idx_lo = r_idx[IdxBits-1:0];
    assign out_free = !r_res_valid || o_res.ready;
    assign i_req.ready = (r_state == SIdle);

    // build the cell row
    for (genvar g = 0; g < TableDepth; g++) begin : g_cell
        logic [IdBits-1:0]     nb_id;
        logic [WeightBits-1:0] nb_w;
        if (g == TableDepth - 1) begin : g_last
            assign nb_id = cell_id[g];
            assign nb_w  = cell_w[g];
        end else begin : g_mid
            assign nb_id = cell_id[g+1];
            assign nb_w  = cell_w[g+1];
        end
        lts_cell u_cell (
            .i_clk      (i_clk),
            .i_pos      (IdxBits'(g)),
            .i_cmd      (cmd),
            .i_nb_id    (nb_id),
            .i_nb_weight(nb_w),
            .o_id       (cell_id[g]),
            .o_weight   (cell_w[g])
        );
    end

    // one restoring-division step and one walk step
    always_comb begin
        logic [TotalBits+1:0] trial;
        trial = {r_rem, r_rand[RandBits-1]};
        if (trial >= {2'b00, r_total}) n_rem = (TotalBits+1)'(trial - {2'b00, r_total});
        else                           n_rem = (TotalBits+1)'(trial);
        n_acc = r_acc + TotalBits'(cell_w[idx_lo]);
    end

    // cell command
    always_comb begin
        cmd        = '0;
        cmd.wr_idx = r_count[IdxBits-1:0];
        cmd.id     = i_req.entry_id;
        cmd.weight = i_req.weight;
        cmd.load   = i_req.valid && i_req.ready && i_req.kind == KindAdd
                     && r_count < CountBits'(TableDepth);
        cmd.del    = (r_state == SScan) && r_idx != '0 && cell_id[IdxBits'(r_idx - 1'b1)] == r_key;
        cmd.del_idx = IdxBits'(r_idx - 1'b1);
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reload <= '0;
        else if (i_cfg_we) r_reload <= i_cfg_wdata;
    end

    // output register valid: set when a result moves in, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (r_state == SOut && out_free) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SIdle;
            r_count     <= '0;
            r_total     <= '0;
            r_quantum   <= '0;
            r_cur_id    <= '0;
            r_cur_valid <= 1'b0;
        end else begin
            case (r_state)
                SIdle: begin
                    if (i_req.valid && i_req.ready) begin
                        r_res.winner_id       <= '0;
                        r_res.winner_valid    <= 1'b0;
                        r_res.running_removed <= 1'b0;
                        r_key   <= i_req.entry_id;
                        r_rand  <= i_req.random_value;
                        case (i_req.kind)
                            KindAdd: begin
                                r_state <= SOut;
                                if (r_count < CountBits'(TableDepth)) begin
                                    r_count      <= r_count + 1'b1;
                                    r_total      <= r_total + TotalBits'(i_req.weight);
                                    r_res.status <= StAdded;
                                end else begin
                                    r_res.status <= StFull;
                                end
                            end
                            KindRemove: begin
                                r_idx   <= r_count;
                                r_state <= SScan;
                            end
                            KindTick: begin
                                if (r_count == '0) begin
                                    r_res.status <= StEmpty;
                                    r_state      <= SOut;
                                end else if (r_quantum != '0) begin
                                    r_quantum    <= r_quantum - 1'b1;
                                    r_res.status <= StWait;
                                    r_state      <= SOut;
                                end else if (r_total == '0) begin
                                    r_res.status <= StEmpty;
                                    r_state      <= SOut;
                                end else begin
                                    r_rem   <= '0;
                                    r_bit   <= '0;
                                    r_state <= SDiv;
                                end
                            end
                            default: r_state <= SIdle;
                        endcase
                    end
                end
                SScan: begin
                    // scan newest first; on a hit close the gap this cycle
                    if (r_idx == '0) begin
                        r_res.status <= StNotFound;
                        r_state      <= SOut;
                    end else if (cmd.del) begin
                        r_total      <= r_total - TotalBits'(cell_w[cmd.del_idx]);
                        r_count      <= r_count - 1'b1;
                        r_res.status <= StRemoved;
                        if (r_cur_valid && r_cur_id == r_key) begin
                            r_cur_valid           <= 1'b0;
                            r_res.running_removed <= 1'b1;
                        end
                        r_state <= SOut;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                SDiv: begin
                    r_rem  <= n_rem;
                    r_rand <= r_rand << 1;
                    r_bit  <= r_bit + 1'b1;
                    if (r_bit == 6'(RandBits - 1)) begin
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= SWalk;
                    end
                end
                SWalk: begin
                    // walk oldest first until the ticket falls below the sum or the last entry is reached
                    r_acc <= n_acc;
                    if ({1'b0, n_acc} > r_rem || r_idx == r_count - 1'b1) begin
                        r_cur_id           <= cell_id[idx_lo];
                        r_cur_valid        <= 1'b1;
                        r_quantum          <= r_reload;
                        r_res.status       <= StDrawn;
                        r_res.winner_id    <= cell_id[idx_lo];
                        r_res.winner_valid <= 1'b1;
                        r_state            <= SOut;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                SOut: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= SIdle;
                    end
                end
                default: r_state <= SIdle;
            endcase
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.status          = r_out.status;
    assign o_res.winner_id       = r_out.winner_id;
    assign o_res.winner_valid    = r_out.winner_valid;
    assign o_res.running_removed = r_out.running_removed;

    // count never exceeds the table depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(TableDepth)) else $error("slot count overflow");
    // a draw result always names a winner
    a_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == StDrawn |-> o_res.winner_valid)
        else $error("draw without winner");
    // running flag only on removes
    a_rr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.running_removed |-> o_res.status == StRemoved)
        else $error("running flag on non-remove");
    // empty table holds no tickets
    a_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_total == '0) else $error("tickets without entries");
endmodule
